// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared concurrent checks for the battery power sequencer, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication, checked on every rising clock edge out of reset
`define BPS_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sequencer implication check failed");

// next-cycle implication, checked on every rising clock edge out of reset
`define BPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sequencer next-cycle check failed");

`else

`define BPS_ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define BPS_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== sv/bps_pkg.sv =====
// ---------------------------------------------------------------------------
// bps_pkg
// shared types, register indices and constants of the battery power sequencer
// ---------------------------------------------------------------------------
package bps_pkg;

    // stream and configuration port widths
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 32;

    // sample scaling: 3300 mV * 16 / 4096 = 825 / 64, 660 mA * 20 / 4096 = 825 / 256
    localparam logic [9:0] SCALE_MUL = 10'd825;
    localparam int         MV_SHIFT  = 6;
    localparam int         MA_SHIFT  = 8;

    // configuration register indices
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CHARGE_INPUT_MIN_MV   = 3'd0,
        CFG_CHARGE_INPUT_MAX_MV   = 3'd1,
        CFG_BATTERY_FULL_MV       = 3'd2,
        CFG_CHARGE_CURRENT_MAX_MA = 3'd3,
        CFG_KEY_FILTER_TICKS      = 3'd4,
        CFG_SHUTDOWN_WAIT_TICKS   = 3'd5,
        CFG_TEMP_MAX              = 3'd6,
        CFG_TEMP_MIN              = 3'd7
    } cfg_idx_t;

    // configuration reset values
    localparam logic [15:0]        RST_CHARGE_INPUT_MIN_MV   = 16'd9000;
    localparam logic [15:0]        RST_CHARGE_INPUT_MAX_MV   = 16'd26000;
    localparam logic [15:0]        RST_BATTERY_FULL_MV       = 16'd16800;
    localparam logic [13:0]        RST_CHARGE_CURRENT_MAX_MA = 14'd3000;
    localparam logic [31:0]        RST_KEY_FILTER_TICKS      = 32'd50;
    localparam logic [31:0]        RST_SHUTDOWN_WAIT_TICKS   = 32'd3000;
    localparam logic signed [15:0] RST_TEMP_MAX              = 16'sd60;
    localparam logic signed [15:0] RST_TEMP_MIN              = -16'sd10;

    typedef struct packed {
        logic [15:0]        charge_input_min_mv;
        logic [15:0]        charge_input_max_mv;
        logic [15:0]        battery_full_mv;
        logic [13:0]        charge_current_max_ma;
        logic [31:0]        key_filter_ticks;
        logic [31:0]        shutdown_wait_ticks;
        logic signed [15:0] temp_max;
        logic signed [15:0] temp_min;
    } cfg_t;

    // one control tick as received
    typedef struct packed {
        logic [31:0]        now_tick;
        logic [11:0]        adc_charger_in;
        logic [11:0]        adc_batt_out_volt;
        logic [11:0]        adc_batt_chg_volt;
        logic [11:0]        adc_batt_chg_curr;
        logic               switch_down;
        logic               wired_charger;
        logic signed [15:0] battery_temp;
    } in_item_t;

    // samples in engineering units
    typedef struct packed {
        logic [15:0] charger_in_mv;
        logic [15:0] batt_out_mv;
        logic [15:0] batt_chg_mv;
        logic [13:0] charge_current_ma;
    } scaled_t;

    // one result item
    typedef struct packed {
        logic        charge_enable;
        logic        battery_out_enable;
        logic        upper_rail_enable;
        logic        main_rail_enable;
        logic [1:0]  power_mode;
        logic [1:0]  charge_mode;
        logic [15:0] charger_in_mv;
        logic [13:0] charge_current_ma;
    } result_t;

endpackage

// ===== sv/bps_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// bps_cfg_regs
// configuration register file, written one register per cycle, no read-back
// ---------------------------------------------------------------------------
module bps_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [bps_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [bps_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output bps_pkg::cfg_t                 cfg
);
    import bps_pkg::*;

    cfg_t cfg_reg;

    // register writes, reset to the documented defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.charge_input_min_mv   <= RST_CHARGE_INPUT_MIN_MV;
            cfg_reg.charge_input_max_mv   <= RST_CHARGE_INPUT_MAX_MV;
            cfg_reg.battery_full_mv       <= RST_BATTERY_FULL_MV;
            cfg_reg.charge_current_max_ma <= RST_CHARGE_CURRENT_MAX_MA;
            cfg_reg.key_filter_ticks      <= RST_KEY_FILTER_TICKS;
            cfg_reg.shutdown_wait_ticks   <= RST_SHUTDOWN_WAIT_TICKS;
            cfg_reg.temp_max              <= RST_TEMP_MAX;
            cfg_reg.temp_min              <= RST_TEMP_MIN;
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_CHARGE_INPUT_MIN_MV:   cfg_reg.charge_input_min_mv   <= cfg_wdata[15:0];
                CFG_CHARGE_INPUT_MAX_MV:   cfg_reg.charge_input_max_mv   <= cfg_wdata[15:0];
                CFG_BATTERY_FULL_MV:       cfg_reg.battery_full_mv       <= cfg_wdata[15:0];
                CFG_CHARGE_CURRENT_MAX_MA: cfg_reg.charge_current_max_ma <= cfg_wdata[13:0];
                CFG_KEY_FILTER_TICKS:      cfg_reg.key_filter_ticks      <= cfg_wdata[31:0];
                CFG_SHUTDOWN_WAIT_TICKS:   cfg_reg.shutdown_wait_ticks   <= cfg_wdata[31:0];
                CFG_TEMP_MAX:              cfg_reg.temp_max              <= $signed(cfg_wdata[15:0]);
                CFG_TEMP_MIN:              cfg_reg.temp_min              <= $signed(cfg_wdata[15:0]);
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/bps_scale.sv =====
// ---------------------------------------------------------------------------
// bps_scale
// constant scaling of the raw 12-bit samples to millivolts and milliamps
// ---------------------------------------------------------------------------
module bps_scale (
    input  bps_pkg::in_item_t item,
    output bps_pkg::scaled_t  scaled
);
    import bps_pkg::*;

    logic [21:0] vin_prod;
    logic [21:0] vbat_prod;
    logic [21:0] vchg_prod;
    logic [21:0] ichg_prod;

    // raw * 825, then a shift drops the power-of-two part of the divisor
    assign vin_prod  = 22'(item.adc_charger_in)    * 22'(SCALE_MUL);
    assign vbat_prod = 22'(item.adc_batt_out_volt) * 22'(SCALE_MUL);
    assign vchg_prod = 22'(item.adc_batt_chg_volt) * 22'(SCALE_MUL);
    assign ichg_prod = 22'(item.adc_batt_chg_curr) * 22'(SCALE_MUL);

    // truncating quotients: at most 52787 mV and 13196 mA
    assign scaled.charger_in_mv     = vin_prod[MV_SHIFT+15:MV_SHIFT];
    assign scaled.batt_out_mv       = vbat_prod[MV_SHIFT+15:MV_SHIFT];
    assign scaled.batt_chg_mv       = vchg_prod[MV_SHIFT+15:MV_SHIFT];
    assign scaled.charge_current_ma = ichg_prod[MA_SHIFT+13:MA_SHIFT];

endmodule

// ===== sv/bps_ctrl.sv =====
// ---------------------------------------------------------------------------
// bps_ctrl
// power-key, charge and power sequencing machines, one tick per step
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bps_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  bps_pkg::in_item_t item,
    input  bps_pkg::scaled_t  scaled,
    input  bps_pkg::cfg_t     cfg,
    output bps_pkg::result_t  result
);
    import bps_pkg::*;

    typedef enum logic [1:0] {
        PWR_OFF         = 2'd0,
        PWR_TURNING_ON  = 2'd1,
        PWR_ON          = 2'd2,
        PWR_TURNING_OFF = 2'd3
    } pwr_t;

    typedef enum logic [1:0] {
        CHG_NONE  = 2'd0,
        CHG_WIRED = 2'd1,
        CHG_DOCK  = 2'd2
    } chg_t;

    typedef enum logic [1:0] {
        KEY_IDLE     = 2'd0,
        KEY_PRESSED  = 2'd1,
        KEY_RELEASED = 2'd2
    } key_t;

    // drive bit positions
    localparam int EN_CHARGE = 0;
    localparam int EN_BATT   = 1;
    localparam int EN_UPPER  = 2;
    localparam int EN_MAIN   = 3;

    pwr_t        power_phase_reg, power_phase_next;
    chg_t        charge_phase_reg, charge_phase_next;
    key_t        key_phase_reg, key_phase_next;
    logic [31:0] press_time_reg, press_time_next;
    logic [31:0] release_time_reg, release_time_next;
    logic        shutdown_armed_reg, shutdown_armed_next;
    logic [31:0] shutdown_start_reg, shutdown_start_next;
    logic [3:0]  enable_reg, enable_next;

    logic signed [16:0] volt_diff;
    logic signed [15:0] temp;
    logic signed [15:0] temp_max;
    logic signed [15:0] temp_min;
    logic               temp_ok;
    logic               charge_start;
    logic               charge_stop;

    // charger input minus charge node, and the temperature window
    assign volt_diff = $signed({1'b0, scaled.charger_in_mv}) - $signed({1'b0, scaled.batt_chg_mv});
    assign temp      = item.battery_temp;
    assign temp_max  = cfg.temp_max;
    assign temp_min  = cfg.temp_min;
    assign temp_ok   = (temp < temp_max) && (temp > temp_min);

    // charge start and stop windows
    assign charge_start = (scaled.charger_in_mv >= cfg.charge_input_min_mv)
                       && (scaled.charger_in_mv <= cfg.charge_input_max_mv)
                       && (scaled.batt_out_mv < cfg.battery_full_mv)
                       && (volt_diff > 17'sd200);
    assign charge_stop  = (scaled.charger_in_mv < cfg.charge_input_min_mv)
                       || (scaled.charge_current_ma > cfg.charge_current_max_ma)
                       || (scaled.batt_chg_mv > cfg.battery_full_mv)
                       || ((volt_diff < 17'sd150) && (volt_diff > -17'sd150));

    // next state of the three machines, in tick order
    // tick differences are 32-bit and wrap modulo 2^32
    always_comb begin
        power_phase_next    = power_phase_reg;
        charge_phase_next   = charge_phase_reg;
        key_phase_next      = key_phase_reg;
        press_time_next     = press_time_reg;
        release_time_next   = release_time_reg;
        shutdown_armed_next = shutdown_armed_reg;
        shutdown_start_next = shutdown_start_reg;
        enable_next         = enable_reg;

        // power key edges
        case (key_phase_reg)
            KEY_IDLE: begin
                if (item.switch_down) begin
                    key_phase_next  = KEY_PRESSED;
                    press_time_next = item.now_tick;
                end
            end
            KEY_PRESSED: begin
                if (!item.switch_down) begin
                    key_phase_next    = KEY_RELEASED;
                    release_time_next = item.now_tick;
                end
            end
            default: ;
        endcase

        // long press holds the battery output, release after a long press toggles power
        if (key_phase_next == KEY_PRESSED
            && (item.now_tick - press_time_next) > cfg.key_filter_ticks) begin
            enable_next[EN_BATT] = 1'b1;
        end
        if (key_phase_next == KEY_RELEASED) begin
            if ((release_time_next - press_time_next) > cfg.key_filter_ticks) begin
                if (power_phase_next == PWR_OFF) begin
                    power_phase_next = PWR_TURNING_ON;
                end else if (power_phase_next == PWR_ON) begin
                    power_phase_next = PWR_TURNING_OFF;
                end
            end
            key_phase_next = KEY_IDLE;
        end

        // charging
        if (charge_phase_next == CHG_NONE && charge_start) begin
            enable_next[EN_CHARGE] = 1'b1;
            charge_phase_next      = item.wired_charger ? CHG_WIRED : CHG_DOCK;
        end
        if (charge_phase_next != CHG_NONE && charge_stop) begin
            enable_next[EN_CHARGE] = 1'b0;
            charge_phase_next      = CHG_NONE;
        end

        // power sequencing
        if (power_phase_next == PWR_TURNING_ON && temp_ok) begin
            enable_next[EN_BATT]  = 1'b1;
            enable_next[EN_UPPER] = 1'b1;
            enable_next[EN_MAIN]  = 1'b1;
            power_phase_next      = PWR_ON;
        end
        if (power_phase_next == PWR_ON && !temp_ok) begin
            power_phase_next = PWR_TURNING_OFF;
        end
        if (power_phase_next == PWR_TURNING_OFF) begin
            if (!shutdown_armed_next) begin
                shutdown_armed_next = 1'b1;
                shutdown_start_next = item.now_tick;
            end
            if ((item.now_tick - shutdown_start_next) > cfg.shutdown_wait_ticks) begin
                power_phase_next    = PWR_OFF;
                enable_next         = '0;
                shutdown_armed_next = 1'b0;
            end
        end
    end

    // machine state, advanced once per tick
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_phase_reg    <= PWR_OFF;
            charge_phase_reg   <= CHG_NONE;
            key_phase_reg      <= KEY_IDLE;
            press_time_reg     <= '0;
            release_time_reg   <= '0;
            shutdown_armed_reg <= 1'b0;
            shutdown_start_reg <= '0;
            enable_reg         <= '0;
        end else if (step) begin
            power_phase_reg    <= power_phase_next;
            charge_phase_reg   <= charge_phase_next;
            key_phase_reg      <= key_phase_next;
            press_time_reg     <= press_time_next;
            release_time_reg   <= release_time_next;
            shutdown_armed_reg <= shutdown_armed_next;
            shutdown_start_reg <= shutdown_start_next;
            enable_reg         <= enable_next;
        end
    end

    // result of this tick, taken after the update
    assign result.charge_enable      = enable_next[EN_CHARGE];
    assign result.battery_out_enable = enable_next[EN_BATT];
    assign result.upper_rail_enable  = enable_next[EN_UPPER];
    assign result.main_rail_enable   = enable_next[EN_MAIN];
    assign result.power_mode         = power_phase_next;
    assign result.charge_mode        = charge_phase_next;
    assign result.charger_in_mv      = scaled.charger_in_mv;
    assign result.charge_current_ma  = scaled.charge_current_ma;

    // rails are only up while on or winding down
    `BPS_ASSERT_IMPLY(a_rails_phase, aclk, aresetn, enable_reg[EN_MAIN] || enable_reg[EN_UPPER], power_phase_reg == PWR_ON || power_phase_reg == PWR_TURNING_OFF)
    // charger enable only with a charge mode
    `BPS_ASSERT_IMPLY(a_charge_phase, aclk, aresetn, enable_reg[EN_CHARGE], charge_phase_reg != CHG_NONE)
    // shutdown timer armed only while turning off
    `BPS_ASSERT_IMPLY(a_armed_phase, aclk, aresetn, shutdown_armed_reg, power_phase_reg == PWR_TURNING_OFF)
    // a release is consumed within its own tick
    `BPS_ASSERT_IMPLY(a_key_settled, aclk, aresetn, 1'b1, key_phase_reg == KEY_IDLE || key_phase_reg == KEY_PRESSED)
    // state moves only on a tick
    `BPS_ASSERT_NEXT(a_state_hold, aclk, aresetn, !step, $stable(enable_reg) && $stable(power_phase_reg) && $stable(charge_phase_reg))

endmodule

// ===== sv/battery_power_sequencer.sv =====
// ---------------------------------------------------------------------------
// battery_power_sequencer
// control-tick sequencer for charging, battery output and switched rails
// ---------------------------------------------------------------------------
// Each transaction on the s_ side is one control tick and yields exactly one
// result transaction on the m_ side. One tick is accepted every clock cycle
// while the m_ side does not stall; a tick goes through an input register,
// one pass of scaling and machine logic, and an output register, and its
// result is presented on the m_ side once the output register is loaded. The
// machine state advances in the same cycle that loads the output register,
// which is what lets the next tick follow directly. s_tready depends
// combinationally on m_tready.
// Configuration writes take effect at the next clock edge and should only be
// made while no tick is in flight.
module battery_power_sequencer (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write port
    input  logic                             cfg_we,
    input  logic [bps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [bps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // tick input
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // now_tick[31:0], adc_charger_in[43:32], adc_batt_out_volt[55:44],
    // adc_batt_chg_volt[67:56], adc_batt_chg_curr[79:68], switch_down[80],
    // wired_charger[81], battery_temp[97:82], zero[103:98]
    input  logic [bps_pkg::IN_TDATA_W-1:0]   s_tdata,
    // result output
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // charge_enable[0], battery_out_enable[1], upper_rail_enable[2],
    // main_rail_enable[3], power_mode[5:4], charge_mode[7:6],
    // charger_in_mv[23:8], charge_current_ma[37:24], zero[39:38]
    output logic [bps_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import bps_pkg::*;

    cfg_t     cfg;
    in_item_t s_item;
    in_item_t in_reg;
    logic     in_valid_reg;
    scaled_t  scaled;
    result_t  result_next;
    result_t  out_reg;
    logic     out_valid_reg;
    logic     advance;
    logic     step;

    // field split of the incoming transaction
    assign s_item.now_tick          = s_tdata[31:0];
    assign s_item.adc_charger_in    = s_tdata[43:32];
    assign s_item.adc_batt_out_volt = s_tdata[55:44];
    assign s_item.adc_batt_chg_volt = s_tdata[67:56];
    assign s_item.adc_batt_chg_curr = s_tdata[79:68];
    assign s_item.switch_down       = s_tdata[80];
    assign s_item.wired_charger     = s_tdata[81];
    assign s_item.battery_temp      = $signed(s_tdata[97:82]);

    // handshake: output register drains or is empty, input register follows
    assign advance  = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_reg <= s_item;
        end
        if (step) begin
            out_reg <= result_next;
        end
    end

    bps_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bps_scale u_scale (
        .item   (in_reg),
        .scaled (scaled)
    );

    bps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (in_reg),
        .scaled  (scaled),
        .cfg     (cfg),
        .result  (result_next)
    );

    // result packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_reg.charge_current_ma,
                       out_reg.charger_in_mv,
                       out_reg.charge_mode,
                       out_reg.power_mode,
                       out_reg.main_rail_enable,
                       out_reg.upper_rail_enable,
                       out_reg.battery_out_enable,
                       out_reg.charge_enable};

endmodule
